// ----- src/vsh_pkg.sv -----
// vsh_pkg: shared types, constants and register codes of the vad segment hysteresis unit
// no dependencies; used by every other file of the block
package vsh_pkg;

  // default parameter values
  localparam int WINDOW_SAMPLES_DEF = 3200;
  localparam int POSITION_BITS_DEF  = 32;

  // fixed field widths
  localparam int PROB_W     = 17;
  localparam int HOP_W      = 16;
  localparam int MS_W       = 16;
  localparam int SLEN_W     = 12;
  localparam int OUT_POS_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // milliseconds to samples, a shift by four
  localparam int MS_SHIFT = 4;

  // register reset values
  localparam logic [PROB_W-1:0] THRESHOLD_RST   = PROB_W'(32768);
  localparam logic [HOP_W-1:0]  HOP_SIZE_RST    = HOP_W'(1600);
  localparam logic [MS_W-1:0]   MIN_SPEECH_RST  = MS_W'(100);
  localparam logic [MS_W-1:0]   MIN_SILENCE_RST = MS_W'(100);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_HOP_SIZE    = 2'd1,
    CFG_MIN_SPEECH  = 2'd2,
    CFG_MIN_SILENCE = 2'd3
  } cfg_idx_t;

  // register set as seen by the core
  typedef struct packed {
    logic [PROB_W-1:0] threshold;
    logic [HOP_W-1:0]  hop_size;
    logic [MS_W-1:0]   seg_min_ms;
    logic [MS_W-1:0]   gap_min_ms;
  } cfg_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic [PROB_W-1:0] speech_probability;
    logic              final_window;
    logic              short_stream;
    logic [SLEN_W-1:0] stream_length;
  } in_beat_t;

endpackage

// ----- src/vsh_if.sv -----
// vsh_in_if and vsh_out_if: valid/ready channels of the vad segment hysteresis unit
// depends on vsh_pkg for field widths
interface vsh_in_if;
  logic                         valid;
  logic                         ready;
  logic [vsh_pkg::PROB_W-1:0]   speech_probability;
  logic                         final_window;
  logic                         short_stream;
  logic [vsh_pkg::SLEN_W-1:0]   stream_length;

  modport source (output valid, speech_probability, final_window, short_stream,
                  stream_length, input ready);
  modport sink   (input valid, speech_probability, final_window, short_stream,
                  stream_length, output ready);
endinterface

interface vsh_out_if;
  logic                          valid;
  logic                          ready;
  logic [vsh_pkg::OUT_POS_W-1:0] segment_start;
  logic [vsh_pkg::OUT_POS_W-1:0] segment_end;

  modport source (output valid, segment_start, segment_end, input ready);
  modport sink   (input valid, segment_start, segment_end, output ready);
endinterface

// ----- src/vsh_cfg_regs.sv -----
// vsh_cfg_regs: configuration register set, written through a plain write port
// depends on vsh_pkg
module vsh_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsh_pkg::CFG_DATA_W-1:0] cfg_data,
  output vsh_pkg::cfg_t                  cfg
);

  vsh_pkg::cfg_t cfg_r;
  vsh_pkg::cfg_t cfg_nxt;

  // decode the write, each register keeps its own low bits
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (vsh_pkg::cfg_idx_t'(cfg_index))
        vsh_pkg::CFG_THRESHOLD:   cfg_nxt.threshold  = cfg_data[vsh_pkg::PROB_W-1:0];
        vsh_pkg::CFG_HOP_SIZE:    cfg_nxt.hop_size   = cfg_data[vsh_pkg::HOP_W-1:0];
        vsh_pkg::CFG_MIN_SPEECH:  cfg_nxt.seg_min_ms = cfg_data[vsh_pkg::MS_W-1:0];
        vsh_pkg::CFG_MIN_SILENCE: cfg_nxt.gap_min_ms = cfg_data[vsh_pkg::MS_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= vsh_pkg::THRESHOLD_RST;
      cfg_r.hop_size   <= vsh_pkg::HOP_SIZE_RST;
      cfg_r.seg_min_ms <= vsh_pkg::MIN_SPEECH_RST;
      cfg_r.gap_min_ms <= vsh_pkg::MIN_SILENCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/vsh_seg_core.sv -----
// vsh_seg_core: segment state and the per-beat open, extend, close and flush decision
// depends on vsh_pkg; state advances on each beat taken from the input register
module vsh_seg_core #(
  parameter int WINDOW_SAMPLES = vsh_pkg::WINDOW_SAMPLES_DEF,
  parameter int POSITION_BITS  = vsh_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vsh_pkg::cfg_t            cfg,
  input  vsh_pkg::in_beat_t        beat,
  input  logic                     step,
  output logic                     emit,
  output logic [POSITION_BITS-1:0] emit_start,
  output logic [POSITION_BITS-1:0] emit_end
);

  // sums are held wide enough for a position plus a scaled millisecond count
  localparam int MS_SAMP_W = vsh_pkg::MS_W + vsh_pkg::MS_SHIFT;
  localparam int SW = ((POSITION_BITS > MS_SAMP_W) ? POSITION_BITS : MS_SAMP_W) + 1;

  logic [POSITION_BITS-1:0] offset_r, offset_nxt;
  logic                     in_seg_r, in_seg_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;
  logic [POSITION_BITS-1:0] lse_r, lse_nxt;

  logic                     speech;
  logic [SW-1:0]            lse_sum, off_sum, gap_sum, len_sum;
  logic [POSITION_BITS-1:0] lse_sp, off_adv;
  logic                     gap_ok, close_seg, seg_open1, long1;
  logic [POSITION_BITS-1:0] begin1, lse1;
  logic [SW-1:0]            silence_samp, speech_samp;

  assign speech       = beat.speech_probability >= cfg.threshold;
  assign silence_samp = SW'(cfg.gap_min_ms) << vsh_pkg::MS_SHIFT;
  assign speech_samp  = SW'(cfg.seg_min_ms) << vsh_pkg::MS_SHIFT;

  // saturating end of a speech window and next window offset
  assign lse_sum = SW'(offset_r) + SW'(WINDOW_SAMPLES);
  assign lse_sp  = (lse_sum[SW-1:POSITION_BITS] != '0) ? '1 : lse_sum[POSITION_BITS-1:0];
  assign off_sum = SW'(offset_r) + SW'(cfg.hop_size);
  assign off_adv = (off_sum[SW-1:POSITION_BITS] != '0) ? '1 : off_sum[POSITION_BITS-1:0];

  // silence gap long enough to close the open segment
  assign gap_sum   = SW'(lse_r) + silence_samp;
  assign gap_ok    = SW'(offset_r) >= gap_sum;
  assign close_seg = !speech && in_seg_r && gap_ok;

  // segment after this window's speech update
  assign seg_open1 = speech ? 1'b1 : (close_seg ? 1'b0 : in_seg_r);
  assign begin1    = (speech && !in_seg_r) ? offset_r : begin_r;
  assign lse1      = speech ? lse_sp : lse_r;
  assign len_sum   = SW'(begin1) + speech_samp;
  assign long1     = SW'(lse1) >= len_sum;

  // result selection: short stream, close, or flush on the final window
  always_comb begin
    if (beat.short_stream) begin
      emit       = speech;
      emit_start = '0;
      emit_end   = POSITION_BITS'(beat.stream_length);
    end else begin
      emit       = long1 && (close_seg || (beat.final_window && seg_open1));
      emit_start = begin1;
      emit_end   = lse1;
    end
  end

  // next state
  always_comb begin
    if (beat.short_stream || beat.final_window) begin
      offset_nxt = '0;
      in_seg_nxt = 1'b0;
      begin_nxt  = '0;
      lse_nxt    = '0;
    end else begin
      offset_nxt = off_adv;
      in_seg_nxt = seg_open1;
      begin_nxt  = begin1;
      lse_nxt    = lse1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      in_seg_r <= 1'b0;
      begin_r  <= '0;
      lse_r    <= '0;
    end else if (step) begin
      offset_r <= offset_nxt;
      in_seg_r <= in_seg_nxt;
      begin_r  <= begin_nxt;
      lse_r    <= lse_nxt;
    end
  end

endmodule

// ----- src/vad_segment_hysteresis_unit.sv -----
// Result path: an accepted input beat waits in the input register until the result register is free
// or being drained, then its result beat is loaded into the result register; none if no segment.
// Throughput: one input beat per cycle while the result register is free or being drained.
// Reset (rst_n low, synchronous): segment state and offset cleared, registers to defaults,
// both pipeline registers emptied.
// depends on vsh_pkg, vsh_if, vsh_cfg_regs and vsh_seg_core
module vad_segment_hysteresis_unit #(
  parameter int WINDOW_SAMPLES = vsh_pkg::WINDOW_SAMPLES_DEF,
  parameter int POSITION_BITS  = vsh_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vsh_in_if.sink                         in_ch,
  vsh_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [vsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsh_pkg::CFG_DATA_W-1:0] cfg_data
);

  vsh_pkg::cfg_t            cfg;
  vsh_pkg::in_beat_t        in_beat_r;
  logic                     in_v_r;
  logic                     out_v_r;
  logic [vsh_pkg::OUT_POS_W-1:0] out_start_r, out_end_r;
  logic                     step, in_take;
  logic                     emit;
  logic [POSITION_BITS-1:0] emit_start, emit_end;

  vsh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register moves on when the result register is free or being drained
  assign step         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || step;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r.speech_probability <= in_ch.speech_probability;
      in_beat_r.final_window       <= in_ch.final_window;
      in_beat_r.short_stream       <= in_ch.short_stream;
      in_beat_r.stream_length      <= in_ch.stream_length;
    end
  end

  vsh_seg_core #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .POSITION_BITS  (POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .beat       (in_beat_r),
    .step       (step),
    .emit       (emit),
    .emit_start (emit_start),
    .emit_end   (emit_end)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= emit;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_start_r <= vsh_pkg::OUT_POS_W'(emit_start);
      out_end_r   <= vsh_pkg::OUT_POS_W'(emit_end);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.segment_start = out_start_r;
  assign out_ch.segment_end   = out_end_r;

endmodule

// ----- src/vsh_checker.sv -----
// vsh_checker: port-level assertions of the vad segment hysteresis unit, bound to the top
// depends on vad_segment_hysteresis_unit and its channel interfaces
module vsh_checker #(
  parameter int POSITION_BITS = vsh_pkg::POSITION_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vsh_pkg::OUT_POS_W-1:0] segment_start,
  input logic [vsh_pkg::OUT_POS_W-1:0] segment_end
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(segment_start) && $stable(segment_end))
    else $error("result beat changed while stalled");

  // input side never waits on a free or draining result register
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with result side free");

  // no result beat straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered after reset");

  // a segment never ends before it starts
  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (POSITION_BITS > vsh_pkg::OUT_POS_W) || (segment_end >= segment_start))
    else $error("segment end before start");

endmodule

bind vad_segment_hysteresis_unit vsh_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_vsh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .segment_start (out_ch.segment_start),
  .segment_end   (out_ch.segment_end)
);

// ----- tb/vad_segment_hysteresis_unit_tb.sv -----
// vad_segment_hysteresis_unit_tb: self-checking regression of the vad segment hysteresis unit
// drives window beats and register writes, predicts every segment and compares result beats
// depends on vsh_pkg, vsh_if (vsh_in_if, vsh_out_if) and vad_segment_hysteresis_unit
module vad_segment_hysteresis_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vsh_pkg::*;

  localparam logic [63:0] WINDOW       = 64'(WINDOW_SAMPLES_DEF);
  localparam logic [63:0] POS_MAX      = (64'd1 << POSITION_BITS_DEF) - 64'd1;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          WIDE_WINDOWS = 40;
  localparam int          REPORT_MAX   = 10;
  localparam int          MAX_GAP      = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] seg_start;
    logic [OUT_POS_W-1:0] seg_end;
  } segment_t;

  // directed row: a window beat, and where obvious the segment it must give
  typedef struct packed {
    in_beat_t beat;
    logic     typed;
    logic     t_hit;
    segment_t t_seg;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // short streams: speech at one, silence, exactly at threshold with final set, just below
    '{'{17'd65536, 1'b0, 1'b1, 12'd3199}, 1'b1, 1'b1, '{32'd0, 32'd3199}},
    '{'{17'd0,     1'b0, 1'b1, 12'd4095}, 1'b1, 1'b0, '0},
    '{'{17'd32768, 1'b1, 1'b1, 12'd0},    1'b1, 1'b1, '{32'd0, 32'd0}},
    '{'{17'd32767, 1'b0, 1'b1, 12'd2048}, 1'b1, 1'b0, '0},
    // raw probability above one opens, speech at threshold extends, silence closes
    '{'{17'h1FFFF, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd32768, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd32767, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    // open then flush on the final window
    '{'{17'd65536, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b1, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    // close and flush in the same final window
    '{'{17'd65536, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b1, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    // short stream discards an open segment
    '{'{17'd65536, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd0,     1'b0, 1'b1, 12'd1},    1'b1, 1'b0, '0},
    '{'{17'd0,     1'b1, 1'b0, 12'd0},    1'b1, 1'b0, '0},
    // short stream with speech over an open segment
    '{'{17'd65536, 1'b0, 1'b0, 12'd0},    1'b0, 1'b0, '0},
    '{'{17'd65536, 1'b1, 1'b1, 12'd100},  1'b1, 1'b1, '{32'd0, 32'd100}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vsh_in_if  in_ch ();
  vsh_out_if out_ch ();

  vad_segment_hysteresis_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // segmenter registers and state as predicted
  logic [PROB_W-1:0] thr_q;
  logic [HOP_W-1:0]  hop_q;
  logic [MS_W-1:0]   min_speech_q;
  logic [MS_W-1:0]   min_silence_q;
  logic [63:0]       win_off;
  logic [63:0]       seg_begin;
  logic [63:0]       speech_end;
  bit                seg_open;

  segment_t seg_expected_q [$];

  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int cycle_count;
  int mismatches;
  int n_windows;
  int n_short;
  int n_final;
  int n_segments;

  function automatic logic [63:0] pos_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > POS_MAX) ? POS_MAX : s;
  endfunction

  function automatic void clear_segment_state();
    win_off    = '0;
    seg_open   = 1'b0;
    seg_begin  = '0;
    speech_end = '0;
  endfunction

  function automatic bit seg_is_long();
    return speech_end >= seg_begin + (64'(min_speech_q) << MS_SHIFT);
  endfunction

  // advance the segmenter by one window; returns 1 when a segment is emitted
  function automatic bit next_segment(input in_beat_t b, output segment_t s);
    bit is_speech;
    bit hit;
    is_speech = b.speech_probability >= thr_q;
    hit = 1'b0;
    s = '0;
    if (b.short_stream) begin
      if (is_speech) begin
        s.seg_end = OUT_POS_W'(b.stream_length);
        hit = 1'b1;
      end
      clear_segment_state();
      return hit;
    end
    if (is_speech) begin
      if (!seg_open) begin
        seg_open  = 1'b1;
        seg_begin = win_off;
      end
      speech_end = pos_add(win_off, WINDOW);
    end else if (seg_open &&
                 win_off >= speech_end + (64'(min_silence_q) << MS_SHIFT)) begin
      if (seg_is_long()) begin
        s = '{seg_begin[OUT_POS_W-1:0], speech_end[OUT_POS_W-1:0]};
        hit = 1'b1;
      end
      seg_open = 1'b0;
    end
    // flush on the final window, else move on by one hop
    if (b.final_window) begin
      if (seg_open && seg_is_long()) begin
        s = '{seg_begin[OUT_POS_W-1:0], speech_end[OUT_POS_W-1:0]};
        hit = 1'b1;
      end
      clear_segment_state();
    end else begin
      win_off = pos_add(win_off, 64'(hop_q));
    end
    return hit;
  endfunction

  // probability on the requested side of the threshold, now and then any raw value
  function automatic logic [PROB_W-1:0] pick_probability(bit want_speech);
    int unsigned hi;
    if ($urandom_range(0, 15) == 0) return PROB_W'($urandom);
    if (want_speech) begin
      hi = (thr_q > 17'd65536) ? 32'h1FFFF : 32'd65536;
      return PROB_W'($urandom_range(hi, thr_q));
    end
    if (thr_q == '0) return PROB_W'($urandom);
    return PROB_W'($urandom_range(thr_q - 1, 0));
  endfunction

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 53; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 53; end
      default:       begin idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  // one window beat: optional gap, wait for acceptance, then predict
  task automatic send_window(input in_beat_t b, input bit typed, input bit t_hit,
                             input segment_t t_seg);
    int       gap;
    bit       hit;
    segment_t seg;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.speech_probability <= b.speech_probability;
    in_ch.final_window       <= b.final_window;
    in_ch.short_stream       <= b.short_stream;
    in_ch.stream_length      <= b.stream_length;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hit = next_segment(b, seg);
    if (typed) begin
      hit = t_hit;
      seg = t_seg;
    end
    if (hit) seg_expected_q.insert(seg_expected_q.size(), seg);
    n_windows++;
    if (b.short_stream) n_short++;
    else if (b.final_window) n_final++;
    @(negedge clk);
  endtask

  // stop offering and let every outstanding segment and empty window leave the pipe
  task automatic wait_segments_drained();
    in_ch.valid <= 1'b0;
    while (seg_expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all four registers, one per cycle, block idle
  task automatic write_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] hop,
                            logic [CFG_DATA_W-1:0] min_sp, logic [CFG_DATA_W-1:0] min_si);
    logic [CFG_DATA_W-1:0] vals [4];
    cfg_idx_t              idx;
    vals = '{thr, hop, min_sp, min_si};
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[int'(idx)];
      case (idx)
        CFG_THRESHOLD:  thr_q         = vals[int'(idx)];
        CFG_HOP_SIZE:   hop_q         = vals[int'(idx)][HOP_W-1:0];
        CFG_MIN_SPEECH: min_speech_q  = vals[int'(idx)][MS_W-1:0];
        default:        min_silence_q = vals[int'(idx)][MS_W-1:0];
      endcase
      @(negedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  // one setting: mostly well-formed streams, some short streams, some noise beats
  task automatic run_phase(idling_t mode, logic [CFG_DATA_W-1:0] thr,
                           logic [CFG_DATA_W-1:0] hop, logic [CFG_DATA_W-1:0] min_sp,
                           logic [CFG_DATA_W-1:0] min_si, int n_items, bit pressure);
    in_beat_t b;
    int       sent;
    int       pick;
    int       stream_left;
    int       run_left;
    bit       broken;
    bit       speaking;
    wait_segments_drained();
    write_regs(thr, hop, min_sp, min_si);
    set_idling(mode);
    sent = 0;
    pick = 0;
    stream_left = 0;
    run_left = 0;
    broken = 1'b0;
    speaking = 1'b0;
    while (sent < n_items) begin
      if (stream_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick >= 16) begin
          stream_left = $urandom_range(1, 40);
          broken = ($urandom_range(0, 9) == 0);
          run_left = 0;
        end
      end
      if (stream_left != 0) begin
        // speech and silence in bursts, final on the last window unless broken
        if (run_left == 0) begin
          speaking = !speaking;
          run_left = speaking ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        run_left--;
        stream_left--;
        b.speech_probability = pick_probability(speaking);
        b.final_window       = (stream_left == 0) && !broken;
        b.short_stream       = 1'b0;
        b.stream_length      = SLEN_W'($urandom);
      end else if (pick < 8) begin
        b.speech_probability = pick_probability(1'($urandom_range(0, 1)));
        b.final_window       = 1'($urandom_range(0, 1));
        b.short_stream       = 1'b1;
        b.stream_length      = SLEN_W'($urandom);
      end else begin
        b = in_beat_t'($urandom);
      end
      send_window(b, 1'b0, 1'b0, '0);
      sent++;
      // long receiver hold-off while windows keep coming, later a full drain
      if (pressure && sent == 60) hold_req = HOLD_CYCLES;
      if (pressure && sent == 130) wait_segments_drained();
    end
  endtask

  // result side ready, with random stalls and requested hold-offs
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [OUT_POS_W-1:0] want,
                                 logic [OUT_POS_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t mismatch on %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
  endtask

  // compare each result beat with the oldest predicted segment; run watchdog
  always @(posedge clk) begin : seg_check
    segment_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("vad_segment_hysteresis_unit regression: fail");
      $finish;
    end else if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_segments++;
      if (seg_expected_q.size() == 0) begin
        report_mismatch("unexpected segment start", '0, out_ch.segment_start);
      end else begin
        want = seg_expected_q.pop_front();
        if (out_ch.segment_start !== want.seg_start)
          report_mismatch("segment_start", want.seg_start, out_ch.segment_start);
        if (out_ch.segment_end !== want.seg_end)
          report_mismatch("segment_end", want.seg_end, out_ch.segment_end);
      end
    end
  end

  initial begin : stimulus
    in_beat_t b;
    in_ch.valid              = 1'b0;
    in_ch.speech_probability = '0;
    in_ch.final_window       = 1'b0;
    in_ch.short_stream       = 1'b0;
    in_ch.stream_length      = '0;
    out_ch.ready             = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_THRESHOLD;
    cfg_data                 = '0;
    rst_n                    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    hold_left = 0;
    thr_q         = THRESHOLD_RST;
    hop_q         = HOP_SIZE_RST;
    min_speech_q  = MIN_SPEECH_RST;
    min_silence_q = MIN_SILENCE_RST;
    clear_segment_state();

    // synchronous reset, released on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed windows at reset register values
    for (int i = 0; i < DIR_ROWS; i++)
      send_window(DIR_TABLE[i].beat, DIR_TABLE[i].typed, DIR_TABLE[i].t_hit,
                  DIR_TABLE[i].t_seg);

    // fixed settings: defaults, low extremes, high extremes, zero hop with raw threshold
    run_phase(IDLE_NONE, 17'd32768, 17'd1600, 17'd100, 17'd100, 200, 1'b1);
    run_phase(IDLE_SENDER, 17'd0, 17'd1, 17'd0, 17'd0, 180, 1'b0);
    run_phase(IDLE_RECEIVER, 17'd65536, 17'd65535, 17'd65535, 17'd65535, 180, 1'b0);
    run_phase(IDLE_BOTH, 17'h1FFFF, 17'h10000, 17'd20, 17'd0, 180, 1'b0);

    // random settings, top data bit set now and then on the 16-bit registers
    for (int k = 0; k < 4; k++)
      run_phase(idling_t'(k), 17'($urandom_range(20000, 50000)),
                {1'($urandom), 16'($urandom_range(1, 4000))},
                {1'($urandom), 16'($urandom_range(0, 400))},
                {1'($urandom), 16'($urandom_range(0, 400))}, 180, 1'b0);

    // long stream at the largest hop, offsets well past the 16-bit range
    wait_segments_drained();
    write_regs(17'd40000, 17'd65535, 17'd0, 17'd0);
    set_idling(IDLE_NONE);
    for (int i = 0; i <= WIDE_WINDOWS; i++) begin
      b.speech_probability = pick_probability($urandom_range(0, 2) == 0);
      b.final_window       = (i == WIDE_WINDOWS);
      b.short_stream       = 1'b0;
      b.stream_length      = SLEN_W'($urandom);
      send_window(b, 1'b0, 1'b0, '0);
    end

    // drain and settle
    wait_segments_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d windows (%0d short-stream, %0d final) over 10 register settings",
             n_windows, n_short, n_final);
    $display("%0d segments compared, %0d mismatches", n_segments, mismatches);
    if (mismatches == 0 && seg_expected_q.size() == 0) begin
      $display("vad_segment_hysteresis_unit regression: pass");
    end else begin
      $display("vad_segment_hysteresis_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/vsh_pkg.sv
src/vsh_if.sv
src/vsh_cfg_regs.sv
src/vsh_seg_core.sv
src/vad_segment_hysteresis_unit.sv
src/vsh_checker.sv
tb/vad_segment_hysteresis_unit_tb.sv
